// ===== hdl/cfcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcc_pkg - shared types and constants for the CAN frame checksum check
// Algorithm codes, register indexes, configuration and result bundles, and
// the byte-fold functions for XOR, 8-bit sum and the two CRC-8 variants.
// ----------------------------------------------------------------------------
package cfcc_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;   // frame length field 0..127, clamped to 64
    localparam int CPOS_W          = 6;   // configured payload positions
    localparam int BPOS_W          = 7;   // running byte position, saturates
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;

    localparam logic [BPOS_W-1:0] BPOS_SAT    = '1;
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [7:0]        POLY_J1850  = 8'h1D;
    localparam logic [7:0]        POLY_AUTOSAR = 8'h2F;
    localparam logic [7:0]        CRC_SEED    = 8'hFF;
    localparam logic [7:0]        CRC_XOROUT  = 8'hFF;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_POS   = 2'd3;

    typedef enum logic [1:0] {
        ALG_XOR     = 2'd0,
        ALG_SUM8    = 2'd1,
        ALG_CRC1D   = 2'd2,
        ALG_AUTOSAR = 2'd3
    } alg_t;

    typedef struct packed {
        alg_t              algorithm;
        logic [CPOS_W-1:0] range_start;
        logic [CPOS_W-1:0] range_end;
        logic [CPOS_W-1:0] check_position;
    } cfg_t;

    typedef struct packed {
        logic              checksum_matches;
        logic [BYTE_W-1:0] stored_value;
        logic              range_error;
        logic [BYTE_W-1:0] checksum_value;
    } result_t;

    // Start value of the running checksum
    function automatic logic [7:0] seed_of(input alg_t alg);
        logic [7:0] s;
        s = 8'h00;
        if (alg == ALG_CRC1D || alg == ALG_AUTOSAR)
        begin
            s = CRC_SEED;
        end
        return s;
    endfunction

    // One byte through a bitwise MSB-first CRC-8, eight shift steps
    function automatic logic [7:0] crc_fold(input logic [7:0] acc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = acc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] fold(input alg_t alg,
                                        input logic [7:0] acc,
                                        input logic [7:0] data);
        logic [7:0] r;
        case (alg)
            ALG_XOR:     r = acc ^ data;
            ALG_SUM8:    r = acc + data;
            ALG_CRC1D:   r = crc_fold(acc, data, POLY_J1850);
            ALG_AUTOSAR: r = crc_fold(acc, data, POLY_AUTOSAR);
            default:     r = acc ^ data;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/can_frame_checksum_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_checksum_check - CAN payload checksum check (XOR/SUM8/CRC-8)
// Folds payload bytes of a frame into a running checksum and reports the
// computed value, range error, stored byte and match flag at frame end.
//
//   channel   dir  handshake          contents
//   s_*       in   s_tvalid/s_tready  one payload byte item, tlast ends frame
//   m_*       out  m_tvalid/m_tready  one result item per frame
//   cfg_*     in   cfg_we             register write, no read-back
//
// One item is taken per cycle while the result side does not stall; a result
// is presented after its last item has passed the input and result registers.
// The running checksum loop is combinational: a full 8-step CRC fold.
// Reset clears the configuration, the frame state and both valid flags.
// A stalled result holds the next item in the input register; s_tready
// drops only when both the input and result registers are full.
// ----------------------------------------------------------------------------
module can_frame_checksum_check (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // data_byte[7:0], frame_length[14:8], 0
    input  logic                               s_tlast,  // last_byte
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,  // checksum_value[7:0], range_error[8],
                                                         // stored_value[16:9], checksum_matches[17], 0
    // configuration
    input  logic                               cfg_we,
    input  logic [cfcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cfcc_pkg::*;

    cfg_t              cfg_reg, cfg_next;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic              in_last_reg;

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    logic              out_free;
    logic              step;
    logic              emit;
    result_t           result;
    logic              in_load;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ALGORITHM:   cfg_next.algorithm      = alg_t'(cfg_data[1:0]);
                REG_RANGE_START: cfg_next.range_start    = cfg_data[CPOS_W-1:0];
                REG_RANGE_END:   cfg_next.range_end      = cfg_data[CPOS_W-1:0];
                REG_CHECK_POS:   cfg_next.check_position = cfg_data[CPOS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{algorithm: ALG_XOR, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake: registered item steps whenever the result register can take it
    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        step           = in_valid_reg && out_free;
        s_tready       = !in_valid_reg || step;
        in_load        = s_tvalid && s_tready;
        in_valid_next  = in_load ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = (step && emit) ? 1'b1 :
                         (m_tready ? 1'b0 : out_valid_reg);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_len_reg  <= s_tdata[14:8];
            in_last_reg <= s_tlast;
        end
    end

    cfcc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .step         (step),
        .data_byte    (in_byte_reg),
        .frame_length (in_len_reg),
        .last_byte    (in_last_reg),
        .emit         (emit),
        .result       (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_data_reg.checksum_matches,
                       out_data_reg.stored_value,
                       out_data_reg.range_error,
                       out_data_reg.checksum_value};

`ifndef SYNTHESIS
    // A waiting result is never overwritten by a new one
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !step)
        else $error("result overwritten while stalled");

    // A held input item is not dropped
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg)
        else $error("input item dropped");

    // A frame end that steps always shows a result next cycle
    a_result_appears: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> out_valid_reg)
        else $error("result missing after frame end");
`endif

endmodule

// ===== hdl/cfcc_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcc_frame - per-frame checksum state and result logic
// Folds one registered payload item into the running checksum, captures the
// byte at the check position, forms the result on the last or empty-frame item.
// ----------------------------------------------------------------------------
module cfcc_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfcc_pkg::cfg_t                cfg,
    input  logic                          step,        // registered item moves on
    input  logic [cfcc_pkg::BYTE_W-1:0]   data_byte,
    input  logic [cfcc_pkg::LEN_W-1:0]    frame_length,
    input  logic                          last_byte,
    output logic                          emit,        // this item ends the frame
    output cfcc_pkg::result_t             result
);
    import cfcc_pkg::*;

    logic [7:0]        running_check_reg, running_check_next;
    logic [BPOS_W-1:0] byte_position_reg, byte_position_next;
    logic [7:0]        captured_reg, captured_next;

    logic              has_data;
    logic              in_range;
    logic [7:0]        acc;
    logic [7:0]        rc_upd;
    logic [7:0]        cap_upd;
    logic [BPOS_W-1:0] pos_upd;
    logic [LEN_W-1:0]  len_c;
    logic              pos_in_frame;
    logic              pos_ok;
    logic              err;
    logic [7:0]        sum;
    logic [7:0]        stored;

    // Fold, capture and count for this item
    always_comb
    begin
        has_data = (frame_length != '0);
        in_range = (byte_position_reg >= BPOS_W'(cfg.range_start)) &&
                   (byte_position_reg <= BPOS_W'(cfg.range_end));
        acc      = (byte_position_reg == BPOS_W'(cfg.range_start)) ?
                   seed_of(cfg.algorithm) : running_check_reg;
        rc_upd   = (has_data && in_range) ?
                   fold(cfg.algorithm, acc, data_byte) : running_check_reg;
        cap_upd  = (has_data && byte_position_reg == BPOS_W'(cfg.check_position)) ?
                   data_byte : captured_reg;
        pos_upd  = (has_data && byte_position_reg != BPOS_SAT) ?
                   byte_position_reg + BPOS_W'(1) : byte_position_reg;
        emit     = !has_data || last_byte;
    end

    // Result of the frame, from the state after this item
    always_comb
    begin
        len_c        = (frame_length > LEN_MAX) ? LEN_MAX : frame_length;
        err          = (cfg.range_start > cfg.range_end) ||
                       (LEN_W'(cfg.range_end) >= len_c) ||
                       (LEN_W'(cfg.range_end) >= LEN_MAX);
        pos_in_frame = (LEN_W'(cfg.check_position) < len_c);
        pos_ok       = pos_in_frame && (BPOS_W'(cfg.check_position) < pos_upd);
        if (err)
        begin
            sum = 8'h00;
        end
        else if (cfg.algorithm == ALG_AUTOSAR)
        begin
            sum = rc_upd ^ CRC_XOROUT;
        end
        else
        begin
            sum = rc_upd;
        end
        stored = pos_ok ? cap_upd : 8'h00;

        result.checksum_value   = sum;
        result.range_error      = err;
        result.stored_value     = stored;
        result.checksum_matches = pos_in_frame && (stored == sum);
    end

    // Next state: hold without an item, clear after the frame's end, else keep the updates
    always_comb
    begin
        running_check_next = running_check_reg;
        byte_position_next = byte_position_reg;
        captured_next      = captured_reg;
        if (step)
        begin
            if (emit)
            begin
                running_check_next = seed_of(cfg.algorithm);
                byte_position_next = '0;
                captured_next      = 8'h00;
            end
            else
            begin
                running_check_next = rc_upd;
                byte_position_next = pos_upd;
                captured_next      = cap_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_check_reg <= 8'h00;
            byte_position_reg <= '0;
            captured_reg      <= 8'h00;
        end
        else
        begin
            running_check_reg <= running_check_next;
            byte_position_reg <= byte_position_next;
            captured_reg      <= captured_next;
        end
    end

`ifndef SYNTHESIS
    // Frame state is cleared after every result
    a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> byte_position_reg == '0 && captured_reg == 8'h00)
        else $error("frame state not cleared after result");

    // Position advances by exactly one on a payload item below saturation
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step && !emit && byte_position_reg != BPOS_SAT
        |=> byte_position_reg == $past(byte_position_reg) + BPOS_W'(1))
        else $error("byte position did not advance by one");

    // Nothing moves without an item
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(byte_position_reg) && $stable(running_check_reg) &&
                  $stable(captured_reg))
        else $error("frame state changed without an item");
`endif

endmodule

// ===== dv/frame_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_verdict_checker - result predictor and comparator for the checksum check
// Watches the configuration port and both stream channels. For every accepted
// item it folds the byte into its own copy of the frame state and, at frame
// end, queues the verdict the block must give. Every accepted result item is
// compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module frame_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // data_byte[7:0], frame_length[14:8], 0
    input  logic                            s_tlast,   // last_byte
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,   // checksum_value[7:0], range_error[8],
                                                       // stored_value[16:9], checksum_matches[17], 0
    input  logic                            cfg_we,
    input  logic [cfcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfcc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              frames_checked
);
    import cfcc_pkg::*;

    // shadow configuration
    alg_t              cfg_alg;
    logic [CPOS_W-1:0] cfg_start;
    logic [CPOS_W-1:0] cfg_end;
    logic [CPOS_W-1:0] cfg_pos;

    // shadow frame state
    logic [7:0]        running_code;
    logic [BPOS_W-1:0] byte_count;
    logic [7:0]        held_byte;

    result_t           expected_verdicts[$];

    function automatic logic [7:0] start_code(input alg_t alg);
        return (alg == ALG_CRC1D || alg == ALG_AUTOSAR) ? CRC_SEED : 8'h00;
    endfunction

    // MSB-first CRC-8 over one byte
    function automatic logic [7:0] crc_byte(input logic [7:0] acc,
                                            input logic [7:0] din,
                                            input logic [7:0] poly);
        logic [7:0] r;
        r = acc ^ din;
        repeat (8)
        begin
            r = {r[6:0], 1'b0} ^ (r[7] ? poly : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] fold_code(input alg_t alg,
                                             input logic [7:0] acc,
                                             input logic [7:0] din);
        logic [7:0] r;
        case (alg)
            ALG_XOR:   r = acc ^ din;
            ALG_SUM8:  r = acc + din;
            ALG_CRC1D: r = crc_byte(acc, din, POLY_J1850);
            default:   r = crc_byte(acc, din, POLY_AUTOSAR);
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [7:0]       din;
        logic [LEN_W-1:0] flen;
        logic [LEN_W-1:0] clen;
        logic [7:0]       acc;
        logic             pos_ok;
        result_t          want;
        if (!rst_n)
        begin
            cfg_alg      = ALG_XOR;
            cfg_start    = '0;
            cfg_end      = '0;
            cfg_pos      = '0;
            running_code = start_code(ALG_XOR);
            byte_count   = '0;
            held_byte    = '0;
            expected_verdicts.delete();
            outstanding  = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALGORITHM:   cfg_alg   = alg_t'(cfg_data[1:0]);
                    REG_RANGE_START: cfg_start = cfg_data;
                    REG_RANGE_END:   cfg_end   = cfg_data;
                    REG_CHECK_POS:   cfg_pos   = cfg_data;
                    default: ;
                endcase
            end

            // result item against the oldest verdict
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with no frame pending, expected none, actual %0h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    compare_field("checksum_value", want.checksum_value, m_tdata[7:0]);
                    compare_field("range_error", 8'(want.range_error), 8'(m_tdata[8]));
                    compare_field("stored_value", want.stored_value, m_tdata[16:9]);
                    compare_field("checksum_matches", 8'(want.checksum_matches),
                                  8'(m_tdata[17]));
                    frames_checked++;
                end
            end

            // input item
            if (s_tvalid && s_tready)
            begin
                din  = s_tdata[7:0];
                flen = s_tdata[14:8];
                if (flen != '0)
                begin
                    if (byte_count >= cfg_start && byte_count <= cfg_end)
                    begin
                        acc = (byte_count == cfg_start) ? start_code(cfg_alg) : running_code;
                        running_code = fold_code(cfg_alg, acc, din);
                    end
                    if (byte_count == cfg_pos)
                    begin
                        held_byte = din;
                    end
                    if (byte_count != BPOS_SAT)
                    begin
                        byte_count = byte_count + 1'b1;
                    end
                end
                // empty frame ends at once, otherwise tlast ends it
                if (flen == '0 || s_tlast)
                begin
                    clen = (flen > LEN_MAX) ? LEN_MAX : flen;
                    want.range_error = (cfg_start > cfg_end) || (cfg_end >= clen);
                    if (want.range_error)
                    begin
                        want.checksum_value = 8'h00;
                    end
                    else if (cfg_alg == ALG_AUTOSAR)
                    begin
                        want.checksum_value = running_code ^ CRC_XOROUT;
                    end
                    else
                    begin
                        want.checksum_value = running_code;
                    end
                    pos_ok = (cfg_pos < clen) && (cfg_pos < byte_count);
                    want.stored_value = pos_ok ? held_byte : 8'h00;
                    want.checksum_matches = (cfg_pos < clen) &&
                                            (want.stored_value == want.checksum_value);
                    expected_verdicts.push_back(want);
                    running_code = start_code(cfg_alg);
                    byte_count   = '0;
                    held_byte    = '0;
                end
            end
            outstanding = expected_verdicts.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the CAN frame checksum check
// Drives payload frames under many register settings: a short directed set
// for each algorithm and the corner cases, then random phases of mostly
// well-formed frames carrying a correct or corrupted check byte, mixed with
// empty, short, overlong and oversized frames. Both stream sides idle at
// random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import cfcc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int ITEM_TARGET  = 1400;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ALGORITHM;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [23:0]           m_tdata;

    int mismatches;
    int outstanding;
    int frames_checked;
    int items_sent   = 0;
    int config_count = 0;
    int cycles       = 0;
    bit steady       = 1'b0;   // no idling on either side while set

    // settings currently loaded, for building check bytes
    alg_t              cur_alg   = ALG_XOR;
    logic [CPOS_W-1:0] cur_start = '0;
    logic [CPOS_W-1:0] cur_end   = '0;
    logic [CPOS_W-1:0] cur_pos   = '0;
    logic [7:0]        frame_buf[$];

    can_frame_checksum_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_verdict_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .frames_checked (frames_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall before each result item
    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // check byte as a sender would compute it over frame_buf
    function automatic logic [7:0] frame_code();
        logic [7:0] acc;
        logic [7:0] poly;
        acc  = (cur_alg == ALG_CRC1D || cur_alg == ALG_AUTOSAR) ? CRC_SEED : 8'h00;
        poly = (cur_alg == ALG_CRC1D) ? POLY_J1850 : POLY_AUTOSAR;
        for (int i = cur_start; i <= cur_end; i++)
        begin
            case (cur_alg)
                ALG_XOR:  acc = acc ^ frame_buf[i];
                ALG_SUM8: acc = acc + frame_buf[i];
                default:
                begin
                    acc = acc ^ frame_buf[i];
                    for (int b = 0; b < 8; b++)
                    begin
                        acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly) : {acc[6:0], 1'b0};
                    end
                end
            endcase
        end
        if (cur_alg == ALG_AUTOSAR)
        begin
            acc = acc ^ CRC_XOROUT;
        end
        return acc;
    endfunction

    task automatic send_item(input logic [7:0] din, input logic [LEN_W-1:0] flen,
                             input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, flen, din};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // empty frame is one item; otherwise the first nbytes of frame_buf
    task automatic send_frame(input logic [LEN_W-1:0] flen, input int nbytes);
        if (flen == '0)
        begin
            send_item(8'($urandom_range(0, 255)), flen, 1'($urandom_range(0, 1)));
        end
        else
        begin
            for (int i = 0; i < nbytes; i++)
            begin
                send_item(frame_buf[i], flen, i == nbytes - 1);
            end
        end
    endtask

    task automatic fill_frame(input int nbytes);
        frame_buf.delete();
        repeat (nbytes) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // stop input and let every pending result drain
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input alg_t alg, input logic [CPOS_W-1:0] rs,
                             input logic [CPOS_W-1:0] re, input logic [CPOS_W-1:0] cp);
        quiesce();
        write_reg(REG_ALGORITHM, CFG_DATA_W'(alg));
        write_reg(REG_RANGE_START, rs);
        write_reg(REG_RANGE_END, re);
        write_reg(REG_CHECK_POS, cp);
        cfg_we    <= 1'b0;
        cur_alg   = alg;
        cur_start = rs;
        cur_end   = re;
        cur_pos   = cp;
        config_count++;
    endtask

    // place the check byte when it lies outside the covered range
    task automatic seal_frame(input bit corrupt);
        if ((cur_pos < cur_start || cur_pos > cur_end) && cur_pos < frame_buf.size())
        begin
            frame_buf[cur_pos] = frame_code();
            if (corrupt)
            begin
                frame_buf[cur_pos] ^= 8'($urandom_range(1, 255));
            end
        end
    endtask

    // mostly well-formed frames, the rest noise of any length
    task automatic random_frame();
        int need;
        int flen;
        int nbytes;
        int clen;
        need = ((cur_end > cur_pos) ? int'(cur_end) : int'(cur_pos)) + 1;
        if ($urandom_range(0, 9) < 7)
        begin
            flen = need + $urandom_range(0, 3);
            if (flen > MAX_FRAME_BYTES)
            begin
                flen = MAX_FRAME_BYTES;
            end
            fill_frame(flen);
            seal_frame($urandom_range(0, 5) == 0);
            send_frame(LEN_W'(flen), flen);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       flen = 0;
                1:       flen = $urandom_range(MAX_FRAME_BYTES + 1, 127);
                default: flen = $urandom_range(1, MAX_FRAME_BYTES);
            endcase
            clen   = (flen > 12) ? 12 : flen;
            nbytes = $urandom_range(1, clen + 3);
            fill_frame(nbytes);
            if ($urandom_range(0, 1))
            begin
                seal_frame(1'b0);
            end
            send_frame(LEN_W'(flen), nbytes);
        end
    endtask

    initial
    begin : stimulus
        alg_t              alg;
        logic [CPOS_W-1:0] rs;
        logic [CPOS_W-1:0] re;
        logic [CPOS_W-1:0] cp;
        int                nframes;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty frame, range error
        send_item(8'hFF, '0, 1'b0);

        // one good frame per algorithm, byte extremes
        configure(ALG_XOR, 6'd0, 6'd2, 6'd3);
        frame_buf = '{8'h00, 8'hFF, 8'hA5, 8'h00};
        seal_frame(1'b0);
        send_frame(LEN_W'(4), 4);
        configure(ALG_SUM8, 6'd0, 6'd2, 6'd3);
        frame_buf = '{8'hFF, 8'hFF, 8'h80, 8'h00};
        seal_frame(1'b0);
        send_frame(LEN_W'(4), 4);
        configure(ALG_CRC1D, 6'd1, 6'd3, 6'd0);
        frame_buf = '{8'h00, 8'h12, 8'h34, 8'h56};
        seal_frame(1'b0);
        send_frame(LEN_W'(4), 4);
        configure(ALG_AUTOSAR, 6'd0, 6'd2, 6'd3);
        frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00};
        seal_frame(1'b0);
        send_frame(LEN_W'(4), 4);

        // start after end: zero checksum still compared with the stored byte
        configure(ALG_SUM8, 6'd5, 6'd2, 6'd1);
        frame_buf = '{8'h11, 8'h00, 8'h22};
        send_frame(LEN_W'(3), 3);

        // oversized length with an early end, then bytes past the length
        configure(ALG_CRC1D, 6'd2, 6'd5, 6'd6);
        frame_buf = '{8'h5A, 8'hC3};
        send_frame(LEN_W'(127), 2);
        frame_buf = '{8'h01, 8'h02, 8'h03, 8'h04};
        send_frame(LEN_W'(2), 4);

        // long frame drives the byte counter into saturation
        configure(ALG_XOR, 6'd0, 6'd63, 6'd63);
        fill_frame(130);
        send_frame(LEN_W'(MAX_FRAME_BYTES), 130);

        // random phases
        while (items_sent < ITEM_TARGET)
        begin
            alg = alg_t'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:
                begin
                    rs = 6'd0;
                    re = 6'd63;
                    cp = 6'($urandom_range(0, 63));
                end
                1:
                begin
                    rs = 6'd63;
                    re = 6'd63;
                    cp = 6'($urandom_range(0, 1) ? 0 : 63);
                end
                2:
                begin
                    rs = 6'($urandom_range(0, 63));
                    re = 6'($urandom_range(0, 63));
                    cp = 6'($urandom_range(0, 63));
                end
                default:
                begin
                    rs = 6'($urandom_range(0, 5));
                    re = rs + 6'($urandom_range(0, 3));
                    cp = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 15)) : re + 6'd1;
                end
            endcase
            configure(alg, rs, re, cp);
            steady  = ($urandom_range(0, 4) == 0);
            nframes = (re > 20 || cp > 20) ? 2 : $urandom_range(6, 14);
            repeat (nframes) random_frame();
            steady = 1'b0;
        end

        quiesce();
        $display("Covered %0d input items and %0d frame results over %0d register settings,",
                 items_sent, frames_checked, config_count);
        $display("all four algorithms, range errors, empty, short and oversized frames.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
